@@ hdl/bfh_pkg.sv @@
// Shared types and constants for the 2x2 box-filter downsampler.
package bfh_pkg;

  localparam int unsigned MAX_WIDTH    = 2048;
  localparam int unsigned MAX_CHANNELS = 4;
  localparam int unsigned MAX_HEIGHT   = 4096;
  localparam int unsigned LINE_DEPTH   = (MAX_WIDTH / 2) * MAX_CHANNELS;

  localparam int unsigned SAMPLE_W = 8;
  localparam int unsigned PAIR_W   = SAMPLE_W + 1;
  localparam int unsigned SUM_W    = SAMPLE_W + 2;
  localparam int unsigned CH_W     = 2;
  localparam int unsigned NCH_W    = 3;
  localparam int unsigned X_W      = 11;
  localparam int unsigned Y_W      = 12;
  localparam int unsigned WIDTH_W  = 12;
  localparam int unsigned HEIGHT_W = 13;
  localparam int unsigned IDX_W    = $clog2(LINE_DEPTH);

  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_DATA_W = HEIGHT_W;

  localparam logic [CFG_ADDR_W-1:0] REG_CHANNEL_COUNT = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_WIDTH   = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_HEIGHT  = 2'd2;

  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W = Q_PTR_W + 1;

  localparam int unsigned OQ_DEPTH = 2;
  localparam int unsigned OQ_PTR_W = $clog2(OQ_DEPTH);
  localparam int unsigned OQ_CNT_W = OQ_PTR_W + 1;

  typedef enum logic [1:0] {
    OP_HOLD  = 2'd0,
    OP_STORE = 2'd1,
    OP_EMIT  = 2'd2
  } bfh_op_e;

  typedef struct packed {
    bfh_op_e              op;
    logic [CH_W-1:0]      chan;
    logic [IDX_W-1:0]     idx;
    logic [SAMPLE_W-1:0]  sample;
    logic                 last;
  } bfh_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } bfh_qstat_t;

endpackage

@@ hdl/bfh_front.sv @@
// Front end: config registers, raster counters and item classification.
module bfh_front
  import bfh_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  push_i,
  input  logic [SAMPLE_W-1:0]   sample_i,
  input  bfh_qstat_t            qstat_i,
  output logic                  full_o,
  output logic                  cmd_push_o,
  output bfh_cmd_t              cmd_o
);

  logic [NCH_W-1:0]    chan_cnt_q;
  logic [WIDTH_W-1:0]  width_q;
  logic [HEIGHT_W-1:0] height_q;

  logic [CH_W-1:0] c_q, c_d;
  logic [X_W-1:0]  x_q, x_d;
  logic [Y_W-1:0]  y_q, y_d;

  logic [NCH_W-1:0]    nch;
  logic [WIDTH_W-1:0]  w, kept_w;
  logic [HEIGHT_W-1:0] h, kept_h;
  logic                accept;
  logic                in_frame;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_cnt_q <= NCH_W'(MAX_CHANNELS);
      width_q    <= WIDTH_W'(MAX_WIDTH);
      height_q   <= HEIGHT_W'(2048);
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_CHANNEL_COUNT: chan_cnt_q <= cfg_wdata_i[NCH_W-1:0];
        REG_IMAGE_WIDTH:   width_q    <= cfg_wdata_i[WIDTH_W-1:0];
        REG_IMAGE_HEIGHT:  height_q   <= cfg_wdata_i[HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // Out-of-range settings saturate: zero acts as one, too large acts as the maximum.
  always_comb begin
    if (chan_cnt_q == '0) nch = NCH_W'(1);
    else if (chan_cnt_q > NCH_W'(MAX_CHANNELS)) nch = NCH_W'(MAX_CHANNELS);
    else nch = chan_cnt_q;

    if (width_q == '0) w = WIDTH_W'(1);
    else if (width_q > WIDTH_W'(MAX_WIDTH)) w = WIDTH_W'(MAX_WIDTH);
    else w = width_q;

    if (height_q == '0) h = HEIGHT_W'(1);
    else if (height_q > HEIGHT_W'(MAX_HEIGHT)) h = HEIGHT_W'(MAX_HEIGHT);
    else h = height_q;

    kept_w = {w[WIDTH_W-1:1], 1'b0};
    kept_h = {h[HEIGHT_W-1:1], 1'b0};
  end

  assign full_o = qstat_i.full;
  assign accept = push_i && !qstat_i.full;

  assign in_frame = (NCH_W'(c_q) < nch) && (WIDTH_W'(x_q) < kept_w)
                    && (HEIGHT_W'(y_q) < kept_h);

  always_comb begin
    if (!x_q[0]) cmd_o.op = OP_HOLD;
    else if (!y_q[0]) cmd_o.op = OP_STORE;
    else cmd_o.op = OP_EMIT;
    cmd_o.chan   = c_q;
    cmd_o.idx    = IDX_W'(IDX_W'(x_q[X_W-1:1]) * IDX_W'(nch)) + IDX_W'(c_q);
    cmd_o.sample = sample_i;
    cmd_o.last   = (WIDTH_W'(x_q) == kept_w - WIDTH_W'(1))
                   && (HEIGHT_W'(y_q) == kept_h - HEIGHT_W'(1))
                   && (NCH_W'(c_q) == nch - NCH_W'(1));
  end

  // Items outside the kept area are consumed and dropped here.
  assign cmd_push_o = accept && in_frame;

  always_comb begin
    c_d = c_q;
    x_d = x_q;
    y_d = y_q;
    if (NCH_W'(c_q) + NCH_W'(1) >= nch) begin
      c_d = '0;
      if (WIDTH_W'(x_q) + WIDTH_W'(1) >= w) begin
        x_d = '0;
        if (HEIGHT_W'(y_q) + HEIGHT_W'(1) >= h) y_d = '0;
        else y_d = y_q + Y_W'(1);
      end else begin
        x_d = x_q + X_W'(1);
      end
    end else begin
      c_d = c_q + CH_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_q <= '0;
      x_q <= '0;
      y_q <= '0;
    end else if (accept) begin
      c_q <= c_d;
      x_q <= x_d;
      y_q <= y_d;
    end
  end

endmodule

@@ hdl/bfh_queue.sv @@
// Short command queue between the front end and the back end.
module bfh_queue
  import bfh_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  bfh_cmd_t   cmd_i,
  input  logic       pop_i,
  output bfh_cmd_t   cmd_o,
  output bfh_qstat_t stat_o
);

  bfh_cmd_t             mem_q [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_q, rd_q;
  logic [Q_CNT_W-1:0]   cnt_q, cnt_d;
  logic                 do_push, do_pop;

  assign stat_o.empty = (cnt_q == '0);
  assign stat_o.full  = (cnt_q == Q_CNT_W'(Q_DEPTH));
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign cmd_o        = mem_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) cnt_d = cnt_q + Q_CNT_W'(1);
    else if (do_pop && !do_push) cnt_d = cnt_q - Q_CNT_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) wr_q <= wr_q + Q_PTR_W'(1);
      if (do_pop) rd_q <= rd_q + Q_PTR_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= cmd_i;
  end

endmodule

@@ hdl/bfh_back.sv @@
// Back end: pair sums, line buffer, averaging and the result queue.
module bfh_back
  import bfh_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bfh_cmd_t            cmd_i,
  input  bfh_qstat_t          qstat_i,
  output logic                cmd_pop_o,
  input  logic                out_pop_i,
  output logic                out_empty_o,
  output logic [SAMPLE_W-1:0] avg_sample_o,
  output logic                last_of_image_o
);

  typedef struct packed {
    logic [SAMPLE_W-1:0] avg;
    logic                last;
  } bfh_res_t;

  logic [PAIR_W-1:0]   line_mem [LINE_DEPTH];
  logic [SAMPLE_W-1:0] hold_q [MAX_CHANNELS];

  logic [PAIR_W-1:0]   pair;
  logic                advance;
  logic                take;

  logic                vb_q;
  logic [PAIR_W-1:0]   pair_q;
  logic [PAIR_W-1:0]   line_rd_q;
  logic                last_q;
  logic [SUM_W-1:0]    sum;

  bfh_res_t             oq_mem_q [OQ_DEPTH];
  logic [OQ_PTR_W-1:0]  oq_wr_q, oq_rd_q;
  logic [OQ_CNT_W-1:0]  oq_cnt_q, oq_cnt_d;
  logic                 oq_full;
  logic                 oq_push, oq_pop;
  bfh_res_t             oq_head;

  // The whole pipeline holds only while a finished result waits on a full queue.
  assign advance   = !(vb_q && oq_full);
  assign take      = advance && !qstat_i.empty;
  assign cmd_pop_o = take;

  assign pair = PAIR_W'(hold_q[cmd_i.chan]) + PAIR_W'(cmd_i.sample);

  always_ff @(posedge clk_i) begin
    if (take && cmd_i.op == OP_HOLD) hold_q[cmd_i.chan] <= cmd_i.sample;
  end

  always_ff @(posedge clk_i) begin
    if (take && cmd_i.op == OP_STORE) line_mem[cmd_i.idx] <= pair;
  end

  always_ff @(posedge clk_i) begin
    if (advance) line_rd_q <= line_mem[cmd_i.idx];
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      pair_q <= pair;
      last_q <= cmd_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vb_q <= 1'b0;
    else if (advance) vb_q <= take && (cmd_i.op == OP_EMIT);
  end

  assign sum = SUM_W'(line_rd_q) + SUM_W'(pair_q);

  assign oq_full     = (oq_cnt_q == OQ_CNT_W'(OQ_DEPTH));
  assign out_empty_o = (oq_cnt_q == '0);
  assign oq_push     = vb_q && !oq_full;
  assign oq_pop      = out_pop_i && !out_empty_o;
  assign oq_head     = oq_mem_q[oq_rd_q];
  assign avg_sample_o    = oq_head.avg;
  assign last_of_image_o = oq_head.last;

  always_comb begin
    oq_cnt_d = oq_cnt_q;
    if (oq_push && !oq_pop) oq_cnt_d = oq_cnt_q + OQ_CNT_W'(1);
    else if (oq_pop && !oq_push) oq_cnt_d = oq_cnt_q - OQ_CNT_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oq_wr_q  <= '0;
      oq_rd_q  <= '0;
      oq_cnt_q <= '0;
    end else begin
      oq_cnt_q <= oq_cnt_d;
      if (oq_push) oq_wr_q <= oq_wr_q + OQ_PTR_W'(1);
      if (oq_pop) oq_rd_q <= oq_rd_q + OQ_PTR_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (oq_push) oq_mem_q[oq_wr_q] <= '{avg: sum[SUM_W-1:2], last: last_q};
  end

endmodule

@@ hdl/box_filter_halve_2x2.sv @@
// Top level of the streaming 2x2 box-filter downsampler.
//
//   channel  handshake           payload
//   -------  ------------------  -----------------------------------------
//   input    push / full         sample_i[7:0]
//   result   empty / pop         avg_sample_o[7:0], last_of_image_o
//   config   cfg_we_i            cfg_addr_i[1:0], cfg_wdata_i[12:0]
//
// Takes one component per clock while full is low and sustains that rate; a
// result reaches the result ports through the command queue, then the line
// buffer read stage, then the result queue. Reset is asynchronous and clears
// the counters and queues; the line buffer is not cleared. A full result
// queue stalls the back end, the command queue then fills and raises full.
module box_filter_halve_2x2
  import bfh_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  push,
  output logic                  full,
  input  logic [SAMPLE_W-1:0]   sample_i,
  output logic                  empty,
  input  logic                  pop,
  output logic [SAMPLE_W-1:0]   avg_sample_o,
  output logic                  last_of_image_o
);

  bfh_cmd_t   front_cmd, queue_cmd;
  bfh_qstat_t qstat;
  logic       cmd_push, cmd_pop;

  bfh_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_addr_i (cfg_addr_i),
    .cfg_wdata_i(cfg_wdata_i),
    .push_i     (push),
    .sample_i   (sample_i),
    .qstat_i    (qstat),
    .full_o     (full),
    .cmd_push_o (cmd_push),
    .cmd_o      (front_cmd)
  );

  bfh_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (cmd_push),
    .cmd_i  (front_cmd),
    .pop_i  (cmd_pop),
    .cmd_o  (queue_cmd),
    .stat_o (qstat)
  );

  bfh_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (queue_cmd),
    .qstat_i        (qstat),
    .cmd_pop_o      (cmd_pop),
    .out_pop_i      (pop),
    .out_empty_o    (empty),
    .avg_sample_o   (avg_sample_o),
    .last_of_image_o(last_of_image_o)
  );

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_push |-> !qstat.full)
    else $error("command pushed into a full queue");

  a_no_pop_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> !qstat.empty)
    else $error("command popped from an empty queue");

  a_queue_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(qstat.empty && qstat.full))
    else $error("command queue both empty and full");

  a_full_follows_queue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full == qstat.full)
    else $error("input full flag disagrees with command queue");

endmodule
